>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the frame builder.
// No dependencies; simulation gets the checks and synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising edge of clk outside reset.
`define CHK_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds on a rising edge of clk outside reset.
`define CHK_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define CHK_PROP(label, clk, rst, prop, msg)
`define CHK_NEVER(label, clk, rst, cond, msg)

`endif

`endif

>>> sv/xbfb_pkg.sv
// Types and constants of the XOR block check frame builder.
// No dependencies; imported by xor_bcc_frame_builder.
`timescale 1ns / 1ps

package xbfb_pkg;

  localparam logic [7:0] SYNC_HEAD      = 8'h55;
  localparam logic [7:0] SYNC_TAIL      = 8'hAA;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd10;
  localparam logic [8:0] FRAME_LEN_MAX  = 9'd255;

  // Position of the result byte within one burst.
  typedef logic [3:0] pos_t;

  localparam pos_t POS_SYNC0   = 4'd0;
  localparam pos_t POS_SYNC1   = 4'd1;
  localparam pos_t POS_LEN     = 4'd2;
  localparam pos_t POS_CRYPTO  = 4'd3;
  localparam pos_t POS_SEQ     = 4'd4;
  localparam pos_t POS_CMD_HI  = 4'd5;
  localparam pos_t POS_CMD_LO  = 4'd6;
  localparam pos_t POS_HDR_BCC = 4'd7;
  localparam pos_t POS_HDR_T0  = 4'd8;
  localparam pos_t POS_HDR_T1  = 4'd9;
  localparam pos_t POS_DATA    = 4'd0;
  localparam pos_t POS_DAT_BCC = 4'd1;
  localparam pos_t POS_DAT_T0  = 4'd2;
  localparam pos_t POS_DAT_T1  = 4'd3;

  // Kind of burst that one accepted request produces.
  typedef enum logic [2:0] {
    MODE_ERR,       // rejected header: one status result
    MODE_HDR,       // header of a frame with payload to follow
    MODE_HDR_FULL,  // header of an empty frame, trailer included
    MODE_DATA,      // payload byte in the middle of a frame
    MODE_DATA_END   // last payload byte, trailer included
  } mode_t;

  // Position of the final byte of a burst.
  function automatic pos_t mode_last(input mode_t mode);
    pos_t last;
    case (mode)
      MODE_HDR:      last = POS_CMD_LO;
      MODE_HDR_FULL: last = POS_HDR_T1;
      MODE_DATA_END: last = POS_DAT_T1;
      default:       last = POS_DATA;
    endcase
    return last;
  endfunction

endpackage

>>> sv/xor_bcc_frame_builder.sv
// Top level of the XOR block check frame builder.
// Depends on xbfb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel  signals                       direction  meaning
//  in       in_valid/in_ready + fields    input      header or payload request
//  cfg      cfg_valid/cfg_ready/cfg_data  input      write of max_frame_len
//  out      out_valid/out_ready + fields  output     frame bytes of each request
//
// One result byte leaves per cycle while out_ready is high. A header request
// makes a burst of 7 bytes (10 for an empty frame, 1 when rejected), a
// payload request 1 byte (4 for the last one, which carries the trailer).
// The burst register and its byte counter set these figures. Reset (rst,
// synchronous) empties both stages and closes any frame; max_frame_len
// returns to 255. A stall on out_ready holds the output register and, once
// the burst register's last byte is waiting, holds in_ready low.

module xor_bcc_frame_builder
  import xbfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [15:0] command,
  input  logic [7:0]  crypto_type,
  input  logic [7:0]  sequence_req,
  input  logic [7:0]  payload_count,
  input  logic [7:0]  data_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        frame_end,
  output logic        status
);

  // Configuration register. Writes are always taken.
  logic [7:0] max_frame_len;

  // Frame state, updated in request order at acceptance.
  logic       frame_open;
  logic [7:0] bytes_left;
  logic [7:0] running_xor;

  // Burst register: what the accepted request must emit, and how far it got.
  logic        desc_valid;
  mode_t       desc_mode;
  pos_t        desc_pos;
  logic [7:0]  desc_len;
  logic [7:0]  desc_crypto;
  logic [7:0]  desc_seq;
  logic [15:0] desc_cmd;
  logic [7:0]  desc_data;
  logic [7:0]  desc_bcc;

  // Byte that the burst register offers to the output register.
  logic [7:0] gen_byte;
  logic       gen_end;
  logic       gen_status;

  logic in_fire;
  logic advance;
  logic desc_is_last;

  // Decode of the request at the input.
  logic [8:0] len_sum;
  logic       len_reject;
  logic [7:0] hdr_xor;
  logic [7:0] data_xor;
  logic       produce;
  mode_t      mode_next;
  logic [7:0] bcc_next;
  logic       frame_open_next;
  logic [7:0] bytes_left_next;
  logic [7:0] running_xor_next;

  assign cfg_ready    = 1'b1;
  assign advance      = desc_valid && (!out_valid || out_ready);
  assign desc_is_last = (desc_pos == mode_last(desc_mode));
  // A new request may enter as soon as the burst register is empty or its
  // final byte moves on in this cycle.
  assign in_ready     = !desc_valid || (advance && desc_is_last);
  assign in_fire      = in_valid && in_ready;

  assign len_sum    = FRAME_OVERHEAD + {1'b0, payload_count};
  assign len_reject = (len_sum > FRAME_LEN_MAX) || (len_sum > {1'b0, max_frame_len});
  // The two sync bytes cancel out of the block check.
  assign hdr_xor    = len_sum[7:0] ^ crypto_type ^ sequence_req ^ command[15:8]
                      ^ command[7:0];
  assign data_xor   = running_xor ^ data_byte;

  always_comb begin
    produce          = 1'b0;
    mode_next        = MODE_ERR;
    bcc_next         = data_xor;
    frame_open_next  = frame_open;
    bytes_left_next  = bytes_left;
    running_xor_next = running_xor;
    if (!req_type) begin
      // A header always closes what was open, with no trailer.
      produce          = 1'b1;
      frame_open_next  = 1'b0;
      bytes_left_next  = 8'd0;
      running_xor_next = 8'd0;
      bcc_next         = hdr_xor;
      if (len_reject) begin
        mode_next = MODE_ERR;
      end else if (payload_count == 8'd0) begin
        mode_next        = MODE_HDR_FULL;
        running_xor_next = hdr_xor;
      end else begin
        mode_next        = MODE_HDR;
        running_xor_next = hdr_xor;
        frame_open_next  = 1'b1;
        bytes_left_next  = payload_count;
      end
    end else if (frame_open) begin
      produce          = 1'b1;
      running_xor_next = data_xor;
      bytes_left_next  = bytes_left - 8'd1;
      if (bytes_left == 8'd1) begin
        mode_next       = MODE_DATA_END;
        frame_open_next = 1'b0;
        bytes_left_next = 8'd0;
      end else begin
        mode_next = MODE_DATA;
      end
    end
  end

  // Byte selection from the burst register.
  always_comb begin
    gen_byte   = 8'd0;
    gen_end    = 1'b0;
    gen_status = 1'b0;
    case (desc_mode)
      MODE_ERR: begin
        gen_end    = 1'b1;
        gen_status = 1'b1;
      end
      MODE_HDR, MODE_HDR_FULL: begin
        case (desc_pos)
          POS_SYNC0, POS_SYNC1:   gen_byte = SYNC_HEAD;
          POS_LEN:                gen_byte = desc_len;
          POS_CRYPTO:             gen_byte = desc_crypto;
          POS_SEQ:                gen_byte = desc_seq;
          POS_CMD_HI:             gen_byte = desc_cmd[15:8];
          POS_CMD_LO:             gen_byte = desc_cmd[7:0];
          POS_HDR_BCC:            gen_byte = desc_bcc;
          POS_HDR_T0, POS_HDR_T1: gen_byte = SYNC_TAIL;
          default:                gen_byte = 8'd0;
        endcase
        gen_end = (desc_mode == MODE_HDR_FULL) && (desc_pos == POS_HDR_T1);
      end
      MODE_DATA, MODE_DATA_END: begin
        case (desc_pos)
          POS_DATA:               gen_byte = desc_data;
          POS_DAT_BCC:            gen_byte = desc_bcc;
          POS_DAT_T0, POS_DAT_T1: gen_byte = SYNC_TAIL;
          default:                gen_byte = 8'd0;
        endcase
        gen_end = (desc_mode == MODE_DATA_END) && (desc_pos == POS_DAT_T1);
      end
      default: begin
        gen_byte = 8'd0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= 8'hFF;
      frame_open    <= 1'b0;
      bytes_left    <= 8'd0;
      running_xor   <= 8'd0;
      desc_valid    <= 1'b0;
      desc_pos      <= POS_SYNC0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_frame_len <= cfg_data;
      end
      if (in_fire) begin
        frame_open  <= frame_open_next;
        bytes_left  <= bytes_left_next;
        running_xor <= running_xor_next;
        desc_valid  <= produce;
        desc_pos    <= POS_SYNC0;
      end else if (advance) begin
        if (desc_is_last) begin
          desc_valid <= 1'b0;
        end else begin
          desc_pos <= desc_pos + pos_t'(1);
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire && produce) begin
      desc_mode   <= mode_next;
      desc_len    <= len_sum[7:0];
      desc_crypto <= crypto_type;
      desc_seq    <= sequence_req;
      desc_cmd    <= command;
      desc_data   <= data_byte;
      desc_bcc    <= bcc_next;
    end
    if (advance) begin
      out_byte  <= gen_byte;
      frame_end <= gen_end;
      status    <= gen_status;
    end
  end

  `CHK_PROP(a_pos_bound, clk, rst, !desc_valid || (desc_pos <= mode_last(desc_mode)),
            "burst position ran past its final byte")
  `CHK_PROP(a_open_count, clk, rst, !frame_open || (bytes_left != 8'd0),
            "open frame with no payload left")
  `CHK_PROP(a_status_end, clk, rst, !(out_valid && status) || frame_end,
            "rejection result without frame end")
  `CHK_NEVER(a_stall_blocks, clk, rst, desc_valid && out_valid && !out_ready && in_ready,
             "request taken while the burst register is stalled")

endmodule
